/* src/lmbs_pkg.sv */
package lmbs_pkg;

   // Fixed field widths of the request word
   localparam int PIX_ROW_W   = 4;
   localparam int PIX_COL_W   = 5;
   localparam int CHAN_W      = 8;
   localparam int PIXEL_W     = 3 * CHAN_W;
   localparam int REQ_DATA_W  = 40;
   localparam int BASE_W      = 10;
   localparam int PLANE_SEL_W = 4;

   // Fixed field widths of the response word
   localparam int RGB_W       = 3;
   localparam int ADDR_PIN_W  = 3;
   localparam int RSP_DATA_W  = 16;

   // Request kinds carried on tuser
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Reset value of the plane base register
   localparam logic [BASE_W-1:0] BASE_RESET = 10'd10;

   // Scan sequence
   typedef enum logic [2:0] {
      PH_DATA,
      PH_CLOCK,
      PH_CLEAR,
      PH_ADDR,
      PH_LATCH_HI,
      PH_LATCH_LO,
      PH_DWELL
   } phase_type;

   // What the response stage does with the color pins
   typedef enum logic [1:0] {
      RGB_HOLD,
      RGB_LOAD,
      RGB_ZERO
   } rgb_op_type;

   // Non-color pin levels
   typedef struct packed {
      logic                  shift_clock;
      logic                  latch;
      logic                  enable_n;
      logic [ADDR_PIN_W-1:0] row_select;
   } pins_type;

   // One bit of each color channel for a plane; planes past bit 7 are dark
   function automatic logic [RGB_W-1:0] plane_bits(input logic [PIXEL_W-1:0] px,
                                                  input logic [PLANE_SEL_W-1:0] plane);
      logic [RGB_W-1:0] bits;
      bits = '0;
      if (plane < PLANE_SEL_W'(CHAN_W)) begin
         bits[0] = px[plane[2:0]];
         bits[1] = px[CHAN_W + 32'(plane[2:0])];
         bits[2] = px[2 * CHAN_W + 32'(plane[2:0])];
      end
      return bits;
   endfunction

endpackage

/* src/led_matrix_bitplane_scanner_unit.sv */
// LED panel scan driver with binary code modulation.
// req channel: tuser is the kind (0 scan tick, 1 pixel write). A pixel write
// stores the RGB value at the given row and column of the frame store; a tick
// advances the scan one step. Every accepted word yields exactly one rsp word
// with the panel pin levels after that step (a write repeats current levels).
// csr channel: writes the base dwell of plane 0 in ticks; always ready. Write
// it only while no request is in flight.
// Pipeline: the frame store read and read stage s1 fill on the accepting edge,
// then the response register, which drives rsp_tvalid.
// Throughput: one word per cycle while rsp_tready is high. The frame store is
// split into an upper-half and a lower-half memory so a data tick reads both
// pixels through one read port each in the same cycle.
// Reset: the frame store is swept to zero, one entry of each half per cycle,
// across all (PANEL_ROWS/2)*PANEL_COLUMNS entries (256 at default size);
// req_tready stays low meanwhile. Pins reset to all low with enable_n high.
// Stall: when rsp_tready is low the response register and one word in the
// read stage hold; req_tready drops only once both are full.
module led_matrix_bitplane_scanner_unit #(
   parameter int PANEL_ROWS    = 16,
   parameter int PANEL_COLUMNS = 32,
   parameter int COLOR_BITS    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: pixel_row[3:0], pixel_column[8:4], red[16:9], green[24:17],
   //            blue[32:25], zero fill [39:33]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lmbs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: func[0]
   input  logic                              req_tuser,
   // rsp_tdata: upper_rgb[2:0], lower_rgb[5:3], shift_clock[6], latch[7],
   //            enable_n[8], row_select[11:9], zero fill [15:12]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lmbs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lmbs_pkg::BASE_W-1:0]       csr_data
);

   localparam int HALF    = PANEL_ROWS / 2;
   localparam int DEPTH   = HALF * PANEL_COLUMNS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ROW_W   = $clog2(HALF);
   localparam int COL_W   = $clog2(PANEL_COLUMNS);
   localparam int PLANE_W = (COLOR_BITS > 1) ? $clog2(COLOR_BITS) : 1;
   localparam int DWELL_W = lmbs_pkg::BASE_W + COLOR_BITS - 1;

   // Request fields
   logic [lmbs_pkg::PIX_ROW_W-1:0] pix_row;
   logic [lmbs_pkg::PIX_COL_W-1:0] pix_col;
   logic [lmbs_pkg::PIXEL_W-1:0]   pix_rgb;
   logic                           req_fire;
   logic                           tick_fire;
   logic                           write_fire;

   assign pix_row  = req_tdata[3:0];
   assign pix_col  = req_tdata[8:4];
   assign pix_rgb  = {req_tdata[32:25], req_tdata[24:17], req_tdata[16:9]};

   // Clearing sweep after reset
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Plane base register
   logic [lmbs_pkg::BASE_W-1:0] base_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= lmbs_pkg::BASE_RESET;
      end else if (csr_valid) begin
         base_ff <= csr_data;
      end
   end

   // Pipeline handshake: read stage s1, then response register
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_move;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clearing_ff && (!s1_valid_ff || s1_move);
   assign req_fire   = req_tvalid && req_tready;
   assign tick_fire  = req_fire && (req_tuser == lmbs_pkg::FUNC_TICK);
   assign write_fire = req_fire && (req_tuser == lmbs_pkg::FUNC_WRITE);

   // Pixel write address decode
   logic                           wr_in_range;
   logic                           wr_lower;
   logic [lmbs_pkg::PIX_ROW_W-1:0] wr_row;
   logic [ADDR_W-1:0]              wr_addr;

   always_comb begin
      wr_in_range = (32'(pix_row) < PANEL_ROWS) && (32'(pix_col) < PANEL_COLUMNS);
      wr_lower    = 32'(pix_row) >= HALF;
      wr_row      = wr_lower ? lmbs_pkg::PIX_ROW_W'(32'(pix_row) - HALF) : pix_row;
      wr_addr     = ADDR_W'(32'(wr_row) * PANEL_COLUMNS + 32'(pix_col));
   end

   // Scan state
   lmbs_pkg::phase_type  phase_ff, phase_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [PLANE_W-1:0]   plane_ff, plane_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [DWELL_W-1:0]   dwell_ff, dwell_in;
   lmbs_pkg::pins_type   pins_ff, pins_in;
   lmbs_pkg::rgb_op_type op_in;
   logic [DWELL_W-1:0]   dwell_len;
   logic                 scan_read;
   logic [ADDR_W-1:0]    scan_addr;

   assign dwell_len = DWELL_W'(base_ff) << plane_ff;
   assign scan_addr = ADDR_W'(32'(row_ff) * PANEL_COLUMNS + 32'(col_ff));

   // Next scan state, pin levels and color op for this word
   always_comb begin
      phase_in  = phase_ff;
      row_in    = row_ff;
      plane_in  = plane_ff;
      col_in    = col_ff;
      dwell_in  = dwell_ff;
      pins_in   = pins_ff;
      op_in     = lmbs_pkg::RGB_HOLD;
      scan_read = 1'b0;
      if (tick_fire) begin
         case (phase_ff)
            lmbs_pkg::PH_DATA: begin
               scan_read           = 1'b1;
               op_in               = lmbs_pkg::RGB_LOAD;
               pins_in.shift_clock = 1'b0;
               pins_in.enable_n    = 1'b1;
               phase_in            = lmbs_pkg::PH_CLOCK;
            end
            lmbs_pkg::PH_CLOCK: begin
               pins_in.shift_clock = 1'b1;
               if ((COL_W + 1)'(col_ff) + 1'b1 >= (COL_W + 1)'(PANEL_COLUMNS)) begin
                  col_in   = '0;
                  phase_in = lmbs_pkg::PH_CLEAR;
               end else begin
                  col_in   = col_ff + 1'b1;
                  phase_in = lmbs_pkg::PH_DATA;
               end
            end
            lmbs_pkg::PH_CLEAR: begin
               op_in               = lmbs_pkg::RGB_ZERO;
               pins_in.shift_clock = 1'b0;
               phase_in            = lmbs_pkg::PH_ADDR;
            end
            lmbs_pkg::PH_ADDR: begin
               pins_in.row_select = lmbs_pkg::ADDR_PIN_W'(32'(row_ff));
               phase_in           = lmbs_pkg::PH_LATCH_HI;
            end
            lmbs_pkg::PH_LATCH_HI: begin
               pins_in.latch = 1'b1;
               phase_in      = lmbs_pkg::PH_LATCH_LO;
            end
            lmbs_pkg::PH_LATCH_LO: begin
               pins_in.latch = 1'b0;
               dwell_in      = '0;
               phase_in      = lmbs_pkg::PH_DWELL;
            end
            lmbs_pkg::PH_DWELL: begin
               pins_in.enable_n = 1'b0;
               // a zero base still lights for one tick
               if ((DWELL_W + 1)'(dwell_ff) + 1'b1 >= (DWELL_W + 1)'(dwell_len)) begin
                  dwell_in = '0;
                  phase_in = lmbs_pkg::PH_DATA;
                  if ((PLANE_W + 1)'(plane_ff) + 1'b1 >= (PLANE_W + 1)'(COLOR_BITS)) begin
                     plane_in = '0;
                     if ((ROW_W + 1)'(row_ff) + 1'b1 >= (ROW_W + 1)'(HALF)) begin
                        row_in = '0;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     plane_in = plane_ff + 1'b1;
                  end
               end else begin
                  dwell_in = dwell_ff + 1'b1;
               end
            end
            default: begin
               phase_in = lmbs_pkg::PH_DATA;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lmbs_pkg::PH_DATA;
         row_ff   <= '0;
         plane_ff <= '0;
         col_ff   <= '0;
         dwell_ff <= '0;
         pins_ff  <= '{shift_clock: 1'b0, latch: 1'b0, enable_n: 1'b1, row_select: '0};
      end else begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         plane_ff <= plane_in;
         col_ff   <= col_in;
         dwell_ff <= dwell_in;
         pins_ff  <= pins_in;
      end
   end

   // Frame store halves: write port shared by the sweep and pixel writes
   logic                         up_we, lo_we;
   logic [ADDR_W-1:0]            mem_waddr;
   logic [lmbs_pkg::PIXEL_W-1:0] mem_wdata;
   logic [lmbs_pkg::PIXEL_W-1:0] up_rd, lo_rd;

   assign up_we     = clearing_ff || (write_fire && wr_in_range && !wr_lower);
   assign lo_we     = clearing_ff || (write_fire && wr_in_range && wr_lower);
   assign mem_waddr = clearing_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clearing_ff ? '0 : pix_rgb;

   lmbs_ram #(
      .WIDTH (lmbs_pkg::PIXEL_W),
      .DEPTH (DEPTH)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (up_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (scan_read),
      .rd_addr (scan_addr),
      .rd_data (up_rd)
   );

   lmbs_ram #(
      .WIDTH (lmbs_pkg::PIXEL_W),
      .DEPTH (DEPTH)
   ) u_lower_ram (
      .clock   (clock),
      .wr_en   (lo_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (scan_read),
      .rd_addr (scan_addr),
      .rd_data (lo_rd)
   );

   // Read stage: waits on the memory data, held while the output stalls
   lmbs_pkg::rgb_op_type s1_op_ff;
   logic [PLANE_W-1:0]   s1_plane_ff;
   lmbs_pkg::pins_type   s1_pins_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= op_in;
         s1_plane_ff <= plane_ff;
         s1_pins_ff  <= pins_in;
      end
   end

   // Response stage: color pin state and output register
   logic [2*lmbs_pkg::RGB_W-1:0]   rgb_ff, rgb_in;
   logic [lmbs_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   always_comb begin
      rgb_in = rgb_ff;
      if (s1_move) begin
         case (s1_op_ff)
            lmbs_pkg::RGB_LOAD: begin
               rgb_in = {lmbs_pkg::plane_bits(lo_rd, lmbs_pkg::PLANE_SEL_W'(s1_plane_ff)),
                         lmbs_pkg::plane_bits(up_rd, lmbs_pkg::PLANE_SEL_W'(s1_plane_ff))};
            end
            lmbs_pkg::RGB_ZERO: begin
               rgb_in = '0;
            end
            default: begin
               rgb_in = rgb_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rgb_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rgb_ff       <= rgb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= {4'b0000, s1_pins_ff.row_select, s1_pins_ff.enable_n,
                         s1_pins_ff.latch, s1_pins_ff.shift_clock, rgb_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* src/lmbs_ram.sv */
module lmbs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
